// ===== design/triangle_facing_cull_and_shade_core_macros.svh =====
// Assertion macros used by the triangle cull and shade checker
`ifndef TRIANGLE_FACING_CULL_AND_SHADE_CORE_MACROS_SVH
`define TRIANGLE_FACING_CULL_AND_SHADE_CORE_MACROS_SVH

// check on every edge out of reset
`define TFCS_ASSERT_RUN(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tfcs check failed");

// check on every edge, reset included
`define TFCS_ASSERT_ALL(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tfcs check failed");

`endif

// ===== design/tfcs_pkg.sv =====
// Shared constants and types of the triangle cull and shade core
package tfcs_pkg;

  localparam int GRAY_W     = 16;
  localparam int NUM_AXES   = 3;
  localparam int NUM_VERTS  = 3;
  localparam int NUM_COORDS = NUM_AXES * NUM_VERTS;
  localparam int FRONT_ST   = 8;

  typedef struct packed {
    logic load;
    logic vis;
  } tfcs_step_ctl_t;

endpackage

// ===== design/tfcs_div_step.sv =====
// One restoring division step of the shade quotient, registered
module tfcs_div_step #(
  parameter int TOT_W = 70
) (
  input  logic                        clk,
  input  tfcs_pkg::tfcs_step_ctl_t    ctl,
  input  logic [TOT_W-1:0]            rem_i,
  input  logic [TOT_W-1:0]            total_i,
  input  logic [tfcs_pkg::GRAY_W-1:0] q_i,
  output logic [TOT_W-1:0]            rem_o,
  output logic [TOT_W-1:0]            total_o,
  output logic [tfcs_pkg::GRAY_W-1:0] q_o,
  output logic                        vis_o
);
  import tfcs_pkg::*;

  logic [TOT_W:0]    rem2;
  logic [TOT_W:0]    diff;
  logic              ge;
  logic [TOT_W-1:0]  rem_nxt;
  logic [GRAY_W-1:0] q_nxt;
  logic [TOT_W-1:0]  rem_r;
  logic [TOT_W-1:0]  total_r;
  logic [GRAY_W-1:0] q_r;
  logic              vis_r;

  always_comb begin
    rem2    = {rem_i, 1'b0};
    diff    = rem2 - {1'b0, total_i};
    ge      = (rem2 >= {1'b0, total_i});
    rem_nxt = ge ? diff[TOT_W-1:0] : rem2[TOT_W-1:0];
    q_nxt   = {q_i[GRAY_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r   <= rem_nxt;
      total_r <= total_i;
      q_r     <= q_nxt;
      vis_r   <= ctl.vis;
    end
  end

  assign rem_o   = rem_r;
  assign total_o = total_r;
  assign q_o     = q_r;
  assign vis_o   = vis_r;

endmodule

// ===== design/triangle_facing_cull_and_shade_core.sv =====
// Top level: triangle facing test and flat shade, deep pipeline
//
//  channel  | dir | tdata (low bit up)                         | tuser
//  ---------+-----+--------------------------------------------+---------
//  in_      | in  | a_x a_y a_z b_x b_y b_z c_x c_y c_z, zeros | -
//  out_     | out | gray_level                                 | visible
//
// One word enters per cycle while in_tready is high; each word passes every stage in order.
// Depth: 8 arithmetic stages for the normal and its squares, then one
// stage per quotient bit of the 16-step division.
// Reset clears only the stage valid bits.
// Stalls pass back through full stages only; empty stages still take words,
// so input keeps flowing while a result waits, until every stage is full.
module triangle_facing_cull_and_shade_core #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero fill
  input  logic [((tfcs_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // gray_level
  output logic [tfcs_pkg::GRAY_W-1:0]                   out_tdata,
  // visible
  output logic                                          out_tuser
);
  import tfcs_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int NW  = PW + 1;
  localparam int MW  = PW;
  localparam int H   = MW / 2;
  localparam int SW  = 2 * MW;
  localparam int TW  = SW + 2;
  localparam int NST = FRONT_ST + GRAY_W;

  logic [NST-1:0] v_r;
  logic [NST-1:0] vin;
  logic [NST:0]   rdy;

  logic signed [CW-1:0] crd [NUM_VERTS][NUM_AXES];

  logic signed [DW-1:0] v_r0 [NUM_AXES];
  logic signed [DW-1:0] w_r0 [NUM_AXES];
  logic signed [PW-1:0] pa_r [NUM_AXES];
  logic signed [PW-1:0] pb_r [NUM_AXES];
  logic signed [NW-1:0] n_r  [NUM_AXES];
  logic        [NW-1:0] n_neg [NUM_AXES];
  logic        [MW-1:0] m_r  [NUM_AXES];
  logic                 vis3_r;
  logic [2*H-1:0]       hh_r [NUM_AXES];
  logic [2*H-1:0]       hl_r [NUM_AXES];
  logic [2*H-1:0]       ll_r [NUM_AXES];
  logic                 vis4_r;
  logic [SW-1:0]        sq_r [NUM_AXES];
  logic                 vis5_r;
  logic [SW:0]          side_r;
  logic [SW-1:0]        sqz_r;
  logic                 vis6_r;
  logic [TW-1:0]        side7_r;
  logic [TW-1:0]        total_r;
  logic                 vis7_r;

  logic [TW-1:0]     rem_c [GRAY_W+1];
  logic [TW-1:0]     tot_c [GRAY_W+1];
  logic [GRAY_W-1:0] q_c   [GRAY_W+1];
  logic              vis_c [GRAY_W+1];

  // valid chain and per-stage advance
  assign vin          = {v_r[NST-2:0], in_tvalid};
  assign rdy[NST]     = out_tready;
  assign in_tready    = rdy[0];

  for (genvar s = 0; s < NST; s++) begin : g_rdy
    assign rdy[s] = !v_r[s] || rdy[s+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NST; s++) begin
        if (rdy[s]) begin
          v_r[s] <= vin[s];
        end
      end
    end
  end

  for (genvar k = 0; k < NUM_VERTS; k++) begin : g_vert
    for (genvar j = 0; j < NUM_AXES; j++) begin : g_axis
      assign crd[k][j] = in_tdata[(k*NUM_AXES+j)*CW +: CW];
    end
  end

  for (genvar j = 0; j < NUM_AXES; j++) begin : g_front
    localparam int J1 = (j + 1) % NUM_AXES;
    localparam int J2 = (j + 2) % NUM_AXES;

    assign n_neg[j] = -n_r[j];

    // edge vectors
    always_ff @(posedge clk) begin
      if (rdy[0]) begin
        v_r0[j] <= {crd[1][j][CW-1], crd[1][j]} - {crd[0][j][CW-1], crd[0][j]};
        w_r0[j] <= {crd[2][j][CW-1], crd[2][j]} - {crd[0][j][CW-1], crd[0][j]};
      end
    end

    // cross product terms
    always_ff @(posedge clk) begin
      if (rdy[1]) begin
        pa_r[j] <= v_r0[J1] * w_r0[J2];
        pb_r[j] <= v_r0[J2] * w_r0[J1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[2]) begin
        n_r[j] <= {pa_r[j][PW-1], pa_r[j]} - {pb_r[j][PW-1], pb_r[j]};
      end
    end

    // magnitude of each normal component
    always_ff @(posedge clk) begin
      if (rdy[3]) begin
        m_r[j] <= n_r[j][NW-1] ? n_neg[j][MW-1:0] : n_r[j][MW-1:0];
      end
    end

    // split squares into half-width partial products
    always_ff @(posedge clk) begin
      if (rdy[4]) begin
        hh_r[j] <= m_r[j][MW-1:H] * m_r[j][MW-1:H];
        hl_r[j] <= m_r[j][MW-1:H] * m_r[j][H-1:0];
        ll_r[j] <= m_r[j][H-1:0]  * m_r[j][H-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[5]) begin
        sq_r[j] <= {hh_r[j], ll_r[j]} + (SW'({hl_r[j], 1'b0}) << H);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      vis3_r <= !n_r[NUM_AXES-1][NW-1] && (n_r[NUM_AXES-1] != '0);
    end
    if (rdy[4]) begin
      vis4_r <= vis3_r;
    end
    if (rdy[5]) begin
      vis5_r <= vis4_r;
    end
    if (rdy[6]) begin
      side_r <= {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
      sqz_r  <= sq_r[2];
      vis6_r <= vis5_r;
    end
    if (rdy[7]) begin
      side7_r <= {1'b0, side_r};
      total_r <= {1'b0, side_r} + {2'b00, sqz_r};
      vis7_r  <= vis6_r;
    end
  end

  // long division, one quotient bit per stage
  assign rem_c[0] = side7_r;
  assign tot_c[0] = total_r;
  assign q_c[0]   = '0;
  assign vis_c[0] = vis7_r;

  for (genvar k = 0; k < GRAY_W; k++) begin : g_div
    tfcs_step_ctl_t ctl;

    assign ctl.load = rdy[FRONT_ST+k];
    assign ctl.vis  = vis_c[k];

    tfcs_div_step #(
      .TOT_W (TW)
    ) u_step (
      .clk     (clk),
      .ctl     (ctl),
      .rem_i   (rem_c[k]),
      .total_i (tot_c[k]),
      .q_i     (q_c[k]),
      .rem_o   (rem_c[k+1]),
      .total_o (tot_c[k+1]),
      .q_o     (q_c[k+1]),
      .vis_o   (vis_c[k+1])
    );
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tuser  = vis_c[GRAY_W];
  assign out_tdata  = vis_c[GRAY_W] ? q_c[GRAY_W] : '0;

endmodule

// ===== design/tfcs_checker.sv =====
// Port checker for the triangle cull and shade core, with its bind
`include "triangle_facing_cull_and_shade_core_macros.svh"

module tfcs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [tfcs_pkg::GRAY_W-1:0] out_tdata,
  input logic                        out_tuser
);
  import tfcs_pkg::*;

  // hold a stalled result word
  `TFCS_ASSERT_RUN(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // a free output lets every stage advance
  `TFCS_ASSERT_RUN(a_ready_flow, out_tready |-> in_tready)

  // drop all words on reset
  `TFCS_ASSERT_ALL(a_reset_empty, !rst_n |=> !out_tvalid)

  // hidden triangles carry no shade
  `TFCS_ASSERT_RUN(a_hidden_dark, out_tvalid && !out_tuser |-> out_tdata == '0)

endmodule

bind triangle_facing_cull_and_shade_core tfcs_checker u_tfcs_checker (.*);
